// File: hw/rtl/hse_pkg.sv
package hse_pkg;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_IDLE      = 2'd1,
    OP_LAST      = 2'd2,
    OP_LAST_BYTE = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IKEY_RUN,
    ST_ABSORB,
    ST_MSG_RUN,
    ST_PAD,
    ST_PAD_RUN,
    ST_OKEY_LOAD,
    ST_OKEY_RUN,
    ST_OUT_LOAD,
    ST_OUT_RUN,
    ST_EMIT
  } state_e;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/hse_front.sv
module hse_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic             has_byte_i,
  input  logic [7:0]       msg_byte_i,
  input  logic             is_last_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output hse_pkg::cmd_t    q_cmd_o
);

  // Two-entry queue of classified commands.
  hse_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  hse_pkg::cmd_t cmd;
  logic          push, pop;

  always_comb begin
    cmd.data = msg_byte_i;
    if (is_last_i && has_byte_i) cmd.op = hse_pkg::OP_LAST_BYTE;
    else if (is_last_i) cmd.op = hse_pkg::OP_LAST;
    else if (has_byte_i) cmd.op = hse_pkg::OP_BYTE;
    else cmd.op = hse_pkg::OP_IDLE;
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif

endmodule

// File: hw/rtl/hse_core.sv
module hse_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [511:0] block_i,
  input  logic [255:0] chain_i,
  output logic         done_o,
  output logic [255:0] digest_o
);

  // One SHA-256 round per cycle; 16-word schedule window.
  logic [31:0]  w_q [16];
  logic [255:0] v_q, h_q;
  logic [5:0]   t_q;
  logic         busy_q, done_q;
  logic [31:0]  a, b, c, d, e, f, g, h, s0, s1, wn, t1, t2;
  logic [31:0]  e1, ch, a0, mj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    {a, b, c, d, e, f, g, h} = v_q;
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    e1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch = (e & f) ^ (~e & g);
    t1 = h + e1 + ch + hse_pkg::round_k(t_q) + w_q[0];
    a0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj = (a & b) ^ (a & c) ^ (b & c);
    t2 = a0 + mj;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511 - 32*i -: 32];
      v_q <= chain_i;
      h_q <= chain_i;
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      t_q    <= 6'd0;
    end else begin
      done_q <= busy_q && (t_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        t_q    <= 6'd0;
      end else if (busy_q) begin
        t_q <= t_q + 6'd1;
        if (t_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_o[255 - 32*i -: 32] = h_q[255 - 32*i -: 32] + v_q[255 - 32*i -: 32];
    end
  end
  assign done_o = done_q;

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without round");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && t_q != 6'd63 |=> busy_q) else $error("rounds cut short");
`endif

endmodule

// File: hw/rtl/hse_back.sv
module hse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  hse_pkg::cmd_t       q_cmd_i,
  input  logic [511:0]        key_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [63:0]         mac_word_o,
  output logic [1:0]          word_index_o
);

  hse_pkg::state_e state_q, state_d;
  logic [511:0] buf_q;
  logic [255:0] chain_q, inner_q;
  logic [63:0]  bits_q;
  logic [5:0]   fill_q;
  logic         second_q;
  logic [1:0]   idx_q;
  logic         last_pend_q;
  logic         start;
  logic [511:0] blk;
  logic [255:0] chain_in;
  logic         done;
  logic [255:0] digest;
  logic [511:0] ipad_blk, opad_blk, pad_blk, out_blk;
  logic [511:0] pad_msk;
  logic         has_b, is_last;
  logic         take;
  logic         spill;

  assign has_b   = (q_cmd_i.op == hse_pkg::OP_BYTE) || (q_cmd_i.op == hse_pkg::OP_LAST_BYTE);
  assign is_last = (q_cmd_i.op == hse_pkg::OP_LAST) || (q_cmd_i.op == hse_pkg::OP_LAST_BYTE);

  // A tail of 56 bytes or more leaves no room for the length field.
  assign spill = !second_q && (fill_q >= 6'd56);

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      ipad_blk[511 - 8*i -: 8] = key_i[511 - 8*i -: 8] ^ hse_pkg::IPAD;
      opad_blk[511 - 8*i -: 8] = key_i[511 - 8*i -: 8] ^ hse_pkg::OPAD;
    end
    // Padding of the message tail: 0x80 after the data, zeros, then length.
    for (int i = 0; i < 64; i++) begin
      if (second_q) pad_blk[511 - 8*i -: 8] = 8'h00;
      else if (6'(i) < fill_q) pad_blk[511 - 8*i -: 8] = buf_q[511 - 8*i -: 8];
      else if (6'(i) == fill_q) pad_blk[511 - 8*i -: 8] = 8'h80;
      else pad_blk[511 - 8*i -: 8] = 8'h00;
    end
    pad_msk = pad_blk;
    if (!spill) pad_msk[63:0] = bits_q;
    out_blk = {inner_q, 8'h80, 184'd0, 64'd768};
  end

  assign q_ready_o = (state_q == hse_pkg::ST_ABSORB);
  assign take      = q_valid_i && q_ready_o;

  always_comb begin
    state_d  = state_q;
    start    = 1'b0;
    blk      = pad_msk;
    chain_in = chain_q;
    case (state_q)
      hse_pkg::ST_IDLE: begin
        // The first beat of a run waits in the queue while the key block is hashed.
        if (q_valid_i) begin
          start = 1'b1; blk = ipad_blk; chain_in = hse_pkg::INIT_H;
          state_d = hse_pkg::ST_IKEY_RUN;
        end
      end
      hse_pkg::ST_IKEY_RUN: if (done) state_d = hse_pkg::ST_ABSORB;
      hse_pkg::ST_ABSORB: begin
        if (take) begin
          if (has_b && fill_q == 6'd63) begin
            start = 1'b1; blk = {buf_q[511:8], q_cmd_i.data};
            state_d = hse_pkg::ST_MSG_RUN;
          end else if (is_last) state_d = hse_pkg::ST_PAD;
        end
      end
      hse_pkg::ST_MSG_RUN: if (done) state_d = last_pend_q ? hse_pkg::ST_PAD :
                                               hse_pkg::ST_ABSORB;
      hse_pkg::ST_PAD: begin
        start = 1'b1; blk = pad_msk; state_d = hse_pkg::ST_PAD_RUN;
      end
      hse_pkg::ST_PAD_RUN: if (done) state_d = spill ? hse_pkg::ST_PAD :
                                               hse_pkg::ST_OKEY_LOAD;
      hse_pkg::ST_OKEY_LOAD: begin
        start = 1'b1; blk = opad_blk; chain_in = hse_pkg::INIT_H;
        state_d = hse_pkg::ST_OKEY_RUN;
      end
      hse_pkg::ST_OKEY_RUN: if (done) state_d = hse_pkg::ST_OUT_LOAD;
      hse_pkg::ST_OUT_LOAD: begin
        start = 1'b1; blk = out_blk; state_d = hse_pkg::ST_OUT_RUN;
      end
      hse_pkg::ST_OUT_RUN: if (done) state_d = hse_pkg::ST_EMIT;
      hse_pkg::ST_EMIT: if (m_ready_i && idx_q == 2'd3) state_d = hse_pkg::ST_IDLE;
      default: state_d = hse_pkg::ST_IDLE;
    endcase
  end

  hse_core u_core (
    .clk_i, .rst_ni, .start_i(start), .block_i(blk), .chain_i(chain_in),
    .done_o(done), .digest_o(digest)
  );

  always_ff @(posedge clk_i) begin
    if (take && has_b) begin
      buf_q[511 - 8*fill_q -: 8] <= q_cmd_i.data;
    end
    if (done) chain_q <= digest;
    if (state_q == hse_pkg::ST_PAD_RUN && done && !spill) inner_q <= digest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hse_pkg::ST_IDLE;
      bits_q      <= 64'd0;
      fill_q      <= 6'd0;
      second_q    <= 1'b0;
      idx_q       <= 2'd0;
      last_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        hse_pkg::ST_IDLE: begin
          bits_q <= 64'd512; fill_q <= 6'd0; second_q <= 1'b0; last_pend_q <= 1'b0;
        end
        hse_pkg::ST_ABSORB: if (take && has_b) begin
          bits_q <= bits_q + 64'd8;
          fill_q <= fill_q + 6'd1;
          // A last flag on the block-completing byte waits for that compression.
          if (fill_q == 6'd63) last_pend_q <= is_last;
        end
        hse_pkg::ST_PAD_RUN: if (done) second_q <= spill;
        hse_pkg::ST_EMIT: if (m_ready_i) idx_q <= idx_q + 2'd1;
        default: ;
      endcase
    end
  end

  assign m_valid_o    = (state_q == hse_pkg::ST_EMIT);
  assign mac_word_o   = chain_q[255 - 64*idx_q -: 64];
  assign word_index_o = idx_q;

`ifndef SYNTH
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_o) |-> idx_q == 2'd0) else $error("emit not at word zero");
  a_start_idle_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !start) else $error("core started twice");
  a_mac_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && !m_ready_i |=> m_valid_o && $stable(mac_word_o))
    else $error("MAC beat changed while stalled");
`endif

endmodule

// File: hw/rtl/hmac_sha256_engine_unit.sv
// After the beat marked last is accepted, the first MAC beat follows three chained
// compressions (tail pad block, outer key block, outer hash), one more when the tail
// needs a second pad block or ends on a full block, and the inner key block first when that
// beat opens the run. Bytes are taken at one per cycle, 64 to a block, while absorbing;
// input stalls during each block compression while the two-entry queue holds further beats.
// Reset (rst_ni low, asynchronous) clears the key registers, queue and control.
module hmac_sha256_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // has_byte[0], msg_byte[8:1], zero fill
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // mac_word[63:0], word_index[65:64], zero fill
  output logic        m_axis_tlast,   // last_word
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]   key_q [8];
  logic [511:0]  key;
  logic          q_valid, q_ready;
  hse_pkg::cmd_t q_cmd;
  logic [63:0]   mac_word;
  logic [1:0]    word_index;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) key_q[i] <= 64'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q[cfg_index_i] <= cfg_data_i;
    end
  end
  always_comb begin
    for (int i = 0; i < 8; i++) key[511 - 64*i -: 64] = key_q[i];
  end

  hse_front u_front (
    .clk_i, .rst_ni, .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .has_byte_i(s_axis_tdata[0]), .msg_byte_i(s_axis_tdata[8:1]),
    .is_last_i(s_axis_tlast), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  hse_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd), .key_i(key),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .mac_word_o(mac_word), .word_index_o(word_index)
  );

  assign m_axis_tdata = {6'd0, word_index, mac_word};
  assign m_axis_tlast = (word_index == 2'd3);

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NUM_KEY_WORDS = 8;
  localparam logic [7:0] INNER_PAD = 8'h36;
  localparam logic [7:0] OUTER_PAD = 8'h5C;
  localparam int DRAIN_CYCLES = 800;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        lst;
  } mac_beat_t;

  typedef struct {
    logic       has;
    logic [7:0] data;
    logic       last;
  } msg_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  hmac_sha256_engine_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [63:0]  key_reg [NUM_KEY_WORDS];
  logic [511:0] msg_block;
  logic [255:0] hash_state;
  logic [63:0]  hashed_bits;
  int           block_fill;
  bit           run_open;

  mac_beat_t mac_q[$];
  int errors, words_checked, runs_done, items_sent, key_writes;
  bit no_gaps;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    logic [255:0] r;
    for (int t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = h[255 - 32 * i -: 32];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) r[255 - 32 * i -: 32] = h[255 - 32 * i -: 32] + v[i];
    return r;
  endfunction

  function automatic logic [511:0] key_block(input logic [7:0] pad);
    logic [511:0] blk;
    for (int i = 0; i < 64; i++) blk[511 - 8 * i -: 8] = key_reg[i / 8][63 - 8 * (i % 8) -: 8] ^ pad;
    return blk;
  endfunction

  // Appends the 0x80 marker and the bit length; a fill past 55 spills into a second block.
  function automatic logic [255:0] sha_finish(input logic [255:0] h, input logic [511:0] blk,
                                              input int fill, input logic [63:0] nbits);
    blk[511 - 8 * fill -: 8] = 8'h80;
    for (int i = fill + 1; i < 64; i++) blk[511 - 8 * i -: 8] = 8'h00;
    if (fill + 1 > 56) begin
      h = sha_compress(h, blk);
      blk = '0;
    end
    blk[63:0] = nbits;
    return sha_compress(h, blk);
  endfunction

  task automatic predict_mac(input logic has, input logic [7:0] data, input logic last);
    logic [255:0] inner, mac;
    mac_beat_t b;
    if (!run_open) begin
      hash_state = sha_compress(SHA_IV, key_block(INNER_PAD));
      hashed_bits = 64'd512;
      block_fill = 0;
      run_open = 1'b1;
    end
    if (has) begin
      msg_block[511 - 8 * block_fill -: 8] = data;
      block_fill++;
      hashed_bits += 64'd8;
      if (block_fill == 64) begin
        hash_state = sha_compress(hash_state, msg_block);
        block_fill = 0;
      end
    end
    if (last) begin
      inner = sha_finish(hash_state, msg_block, block_fill, hashed_bits);
      mac = sha_compress(sha_compress(SHA_IV, key_block(OUTER_PAD)),
                         {inner, 8'h80, 184'b0, 64'd768});
      for (int k = 0; k < 4; k++) begin
        b.word = mac[255 - 64 * k -: 64];
        b.idx = 2'(k);
        b.lst = (k == 3);
        mac_q.push_back(b);
      end
      run_open = 1'b0;
      runs_done++;
    end
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_msg(input logic has, input logic [7:0] data, input logic last);
    int gap;
    gap = rand_gap();
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {7'b0, data, has};
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_mac(has, data, last);
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_key(input int idx, input logic [63:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = 3'(idx);
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_reg[idx] = value;
    key_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Key words only change once all MACs are out and the engine has had time to settle.
  task automatic wait_quiet();
    wait (mac_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_key(input int used_words, input bit all_ones);
    for (int i = 0; i < NUM_KEY_WORDS; i++)
      write_key(i, all_ones ? '1 : (i < used_words ? {$urandom, $urandom} : 64'd0));
  endtask

  // Receiver with random back-pressure.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        stall = rand_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    mac_beat_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mac_q.size() == 0) begin
        $display("%0t: unexpected MAC beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_b = mac_q.pop_front();
        words_checked++;
        if (m_axis_tdata[63:0] !== exp_b.word) begin
          $display("%0t: mac_word expected %h actual %h", $time, exp_b.word, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[65:64] !== exp_b.idx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, exp_b.idx,
                   m_axis_tdata[65:64]);
          errors++;
        end
        if (m_axis_tdata[71:66] !== 6'b0) begin
          $display("%0t: tdata fill expected 0 actual %h", $time, m_axis_tdata[71:66]);
          errors++;
        end
        if (m_axis_tlast !== exp_b.lst) begin
          $display("%0t: last_word expected %b actual %b", $time, exp_b.lst, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    msg_item_t directed [11];
    int len;
    logic last_has;
    directed = '{
      '{1'b0, 8'h00, 1'b1},                         // empty message
      '{1'b0, 8'h5a, 1'b0}, '{1'b0, 8'h00, 1'b1},   // idle beat, then empty message
      '{1'b1, 8'h00, 1'b1},                         // single byte carried with last
      '{1'b1, 8'hff, 1'b1},
      '{1'b1, 8'h61, 1'b0}, '{1'b1, 8'h62, 1'b0}, '{1'b1, 8'h63, 1'b1},
      '{1'b1, 8'h55, 1'b0}, '{1'b0, 8'haa, 1'b0}, '{1'b1, 8'haa, 1'b1}};
    for (int i = 0; i < NUM_KEY_WORDS; i++) key_reg[i] = '0;
    msg_block = '0;
    hash_state = SHA_IV;
    run_open = 1'b0;
    no_gaps = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pass with the reset key, then with every key bit set.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        wait_quiet();
        load_key(NUM_KEY_WORDS, 1'b1);
      end
      foreach (directed[i]) send_msg(directed[i].has, directed[i].data, directed[i].last);
    end

    while (items_sent < 105) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        wait_quiet();
        load_key($urandom_range(1, NUM_KEY_WORDS), 1'b0);
      end
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(54, 72);
      last_has = (len > 0) && $urandom_range(0, 1);
      for (int n = 0; n < len - last_has; n++) begin
        if ($urandom_range(0, 9) == 0) send_msg(1'b0, 8'($urandom), 1'b0);
        send_msg(1'b1, 8'($urandom), 1'b0);
        // Occasionally swap a key word mid-message; only the outer pad sees it.
        if (n == 2 && $urandom_range(0, 3) == 0) begin
          wait_quiet();
          write_key($urandom_range(0, NUM_KEY_WORDS - 1), {$urandom, $urandom});
        end
      end
      send_msg(last_has, 8'($urandom), 1'b1);
    end

    wait (mac_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d MAC runs over %0d input beats with %0d key register writes;",
             runs_done, items_sent, key_writes);
    $display("%0d MAC words compared under random gaps and back-pressure.", words_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hse_pkg.sv
hw/rtl/hse_front.sv
hw/rtl/hse_core.sv
hw/rtl/hse_back.sv
hw/rtl/hmac_sha256_engine_unit.sv
verif/tb.sv
